// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CHK_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/vsc_pkg.sv -----
// shared types and constants of the vigenere stream cipher unit
`default_nettype none

package vsc_pkg;

    localparam int CHAR_W       = 8;
    localparam int LETTER_W     = 5;
    localparam int KEY_LEN_W    = 6;
    localparam int KEY_REG_W    = 60;
    localparam int LETTERS_PER_REG = 12;
    localparam int CFG_IDX_W    = 3;
    localparam int MAX_KEY_LETTERS_DEF = 48;
    localparam int QUEUE_DEPTH  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_A   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_B   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_C   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_D   = 3'd5;

    // cipher modes
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    localparam logic [CHAR_W-1:0]   UC_A = 8'h41;
    localparam logic [CHAR_W-1:0]   UC_Z = 8'h5A;
    localparam logic [CHAR_W-1:0]   LC_A = 8'h61;
    localparam logic [CHAR_W-1:0]   LC_Z = 8'h7A;
    localparam logic [LETTER_W-1:0] MAX_LETTER = 5'd25;
    localparam logic [KEY_LEN_W-1:0] ALPHABET = 6'd26;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              first_of_message;
        logic              last_of_message;
    } src_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              last_out;
    } dst_item_t;

    typedef struct packed {
        logic                 cipher_mode;
        logic [KEY_LEN_W-1:0] key_length;
    } cfg_t;

    // classified character handed from front to back
    typedef struct packed {
        logic [CHAR_W-1:0]   char_in;
        logic                is_letter;
        logic                is_upper;
        logic [LETTER_W-1:0] key;
        logic                cipher_mode;
        logic                last;
    } work_t;

endpackage

`default_nettype wire

// ----- sv/vsc_front.sv -----
// front end: classifies characters, tracks key position, picks key letter
`default_nettype none

module vsc_front #(
    parameter int MAX_KEY_LETTERS = vsc_pkg::MAX_KEY_LETTERS_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire vsc_pkg::cfg_t                              cfg,
    input  wire logic [MAX_KEY_LETTERS*vsc_pkg::LETTER_W-1:0] key_bits,
    input  wire logic                                       src_valid,
    input  wire vsc_pkg::src_item_t                         src_item,
    input  wire logic                                       q_full,
    output logic                                            push,
    output vsc_pkg::work_t                                  push_entry
);

    localparam int KEY_BITS = MAX_KEY_LETTERS * vsc_pkg::LETTER_W;
    localparam int OFF_W    = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

    logic [vsc_pkg::KEY_LEN_W-1:0] pos_reg;
    logic [vsc_pkg::KEY_LEN_W-1:0] pos_next;
    logic [vsc_pkg::KEY_LEN_W-1:0] pos_eff;
    logic [vsc_pkg::KEY_LEN_W-1:0] len_eff;
    logic [vsc_pkg::KEY_LEN_W-1:0] idx;
    logic [vsc_pkg::KEY_LEN_W-1:0] adv;
    logic [OFF_W-1:0]              off;
    logic [vsc_pkg::LETTER_W-1:0]  key_raw;
    logic                          is_lower;
    logic                          is_upper;

    assign push = src_valid && !q_full;

    always_comb
    begin
        // key length zero acts as one, too long saturates
        if (cfg.key_length == '0)
            len_eff = vsc_pkg::KEY_LEN_W'(1);
        else if (cfg.key_length > vsc_pkg::KEY_LEN_W'(MAX_KEY_LETTERS))
            len_eff = vsc_pkg::KEY_LEN_W'(MAX_KEY_LETTERS);
        else
            len_eff = cfg.key_length;

        pos_eff = src_item.first_of_message ? '0 : pos_reg;
        // position left beyond a shortened key restarts at zero
        idx = (pos_eff < len_eff) ? pos_eff : '0;
        adv = idx + vsc_pkg::KEY_LEN_W'(1);

        is_lower = (src_item.char_in >= vsc_pkg::LC_A) && (src_item.char_in <= vsc_pkg::LC_Z);
        is_upper = (src_item.char_in >= vsc_pkg::UC_A) && (src_item.char_in <= vsc_pkg::UC_Z);

        off     = OFF_W'(idx) * OFF_W'(vsc_pkg::LETTER_W);
        key_raw = key_bits[off +: vsc_pkg::LETTER_W];

        push_entry.char_in     = src_item.char_in;
        push_entry.is_letter   = is_lower || is_upper;
        push_entry.is_upper    = is_upper;
        push_entry.key         = (key_raw > vsc_pkg::MAX_LETTER) ? vsc_pkg::MAX_LETTER : key_raw;
        push_entry.cipher_mode = cfg.cipher_mode;
        push_entry.last        = src_item.last_of_message;

        if (is_lower || is_upper)
            pos_next = (adv >= len_eff) ? '0 : adv;
        else
            pos_next = pos_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (push)
            pos_reg <= pos_next;
    end

endmodule

`default_nettype wire

// ----- sv/vsc_queue.sv -----
// small fifo between front and back ends
`default_nettype none

module vsc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire vsc_pkg::work_t push_entry,
    input  wire logic           pop,
    output logic                full,
    output logic                q_valid,
    output vsc_pkg::work_t      q_entry
);

    localparam int PTR_W = (vsc_pkg::QUEUE_DEPTH > 1) ? $clog2(vsc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(vsc_pkg::QUEUE_DEPTH + 1);

    vsc_pkg::work_t    entry_reg [vsc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full    = (count_reg == CNT_W'(vsc_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(vsc_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(vsc_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// ----- sv/vsc_back.sv -----
// back end: mod-26 shift and output register
`default_nettype none

module vsc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire vsc_pkg::work_t q_entry,
    output logic                pop,
    output logic                dst_valid,
    input  wire logic           dst_stall,
    output vsc_pkg::dst_item_t  dst_item
);

    logic                           out_valid_reg;
    logic                           out_valid_next;
    vsc_pkg::dst_item_t             out_item_reg;
    vsc_pkg::dst_item_t             out_item_next;
    logic [vsc_pkg::LETTER_W-1:0]   ofs;
    logic [vsc_pkg::KEY_LEN_W-1:0]  sum;
    logic [vsc_pkg::KEY_LEN_W-1:0]  diff;
    logic [vsc_pkg::KEY_LEN_W-1:0]  shifted;
    logic [vsc_pkg::CHAR_W-1:0]     base;

    assign pop       = q_valid && (!out_valid_reg || !dst_stall);
    assign dst_valid = out_valid_reg;
    assign dst_item  = out_item_reg;

    always_comb
    begin
        // 'A' and 'a' share their low five bits
        ofs  = q_entry.char_in[vsc_pkg::LETTER_W-1:0] - vsc_pkg::UC_A[vsc_pkg::LETTER_W-1:0];
        sum  = {1'b0, ofs} + {1'b0, q_entry.key};
        diff = {1'b0, ofs} - {1'b0, q_entry.key};
        base = q_entry.is_upper ? vsc_pkg::UC_A : vsc_pkg::LC_A;

        if (q_entry.cipher_mode == vsc_pkg::MODE_DECRYPT)
            shifted = diff[vsc_pkg::KEY_LEN_W-1] ? diff + vsc_pkg::ALPHABET : diff;
        else
            shifted = (sum >= vsc_pkg::ALPHABET) ? sum - vsc_pkg::ALPHABET : sum;

        out_item_next.last_out = q_entry.last;
        if (q_entry.is_letter)
            out_item_next.char_out = base + vsc_pkg::CHAR_W'(shifted[vsc_pkg::LETTER_W-1:0]);
        else
            out_item_next.char_out = q_entry.char_in;

        if (pop)
            out_valid_next = 1'b1;
        else if (!dst_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire

// ----- sv/vigenere_stream_cipher_unit.sv -----
// top level of the vigenere stream cipher unit
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  src     | in        | src_valid, src_stall | src_item: char, first, last flags
//  dst     | out       | dst_valid, dst_stall | dst_item: char, last flag
//  cfg     | in        | cfg_we               | cfg_index, cfg_data (60 bits)
//
// one character per cycle sustained while dst is not stalled; a character passes through
// the queue and then the output register; the front end updates the key position in
// the cycle of the transfer, the back end does the mod-26 shift into the output register
// a two-entry queue sits between them, so src stays open while dst is stalled once
// reset clears key position, queue, output valid and config registers (key length to one)
// src_stall rises only when the queue is full behind a stalled output register
`default_nettype none

module vigenere_stream_cipher_unit #(
    parameter int MAX_KEY_LETTERS = vsc_pkg::MAX_KEY_LETTERS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // character input
    input  wire logic                             src_valid,
    output logic                                  src_stall,
    input  wire vsc_pkg::src_item_t               src_item,
    // character output
    output logic                                  dst_valid,
    input  wire logic                             dst_stall,
    output vsc_pkg::dst_item_t                    dst_item,
    // register writes
    input  wire logic                             cfg_we,
    input  wire logic [vsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vsc_pkg::KEY_REG_W-1:0]    cfg_data
);

    localparam int KEY_BITS = MAX_KEY_LETTERS * vsc_pkg::LETTER_W;

    vsc_pkg::cfg_t         cfg_reg;
    vsc_pkg::cfg_t         cfg_next;
    logic [KEY_BITS-1:0]   key_bits_reg;
    logic [KEY_BITS-1:0]   key_bits_next;

    logic                  push;
    vsc_pkg::work_t        push_entry;
    logic                  pop;
    logic                  q_full;
    logic                  q_valid;
    vsc_pkg::work_t        q_entry;

    // register file: mode and length by index, key letters twelve per register
    always_comb
    begin
        cfg_next      = cfg_reg;
        key_bits_next = key_bits_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                vsc_pkg::REG_MODE:    cfg_next.cipher_mode = cfg_data[0];
                vsc_pkg::REG_KEY_LEN: cfg_next.key_length  = cfg_data[vsc_pkg::KEY_LEN_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
            // letters that exist in storage take their slot of the written key register
            for (int j = 0; j < MAX_KEY_LETTERS; j++)
            begin
                if (cfg_index == vsc_pkg::CFG_IDX_W'(vsc_pkg::REG_KEY_A
                                 + j / vsc_pkg::LETTERS_PER_REG))
                    key_bits_next[j*vsc_pkg::LETTER_W +: vsc_pkg::LETTER_W] =
                        cfg_data[(j % vsc_pkg::LETTERS_PER_REG)*vsc_pkg::LETTER_W
                                 +: vsc_pkg::LETTER_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cipher_mode <= vsc_pkg::MODE_ENCRYPT;
            cfg_reg.key_length  <= vsc_pkg::KEY_LEN_W'(1);
            key_bits_reg        <= '0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            key_bits_reg <= key_bits_next;
        end
    end

    // front end accepts whenever the queue has room
    assign src_stall = q_full;

    vsc_front #(
        .MAX_KEY_LETTERS (MAX_KEY_LETTERS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .key_bits   (key_bits_reg),
        .src_valid  (src_valid),
        .src_item   (src_item),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    vsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    vsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .pop       (pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

endmodule

`default_nettype wire

// ----- sv/vsc_checker.sv -----
// port-level checks of the vigenere stream cipher unit and their bind
`default_nettype none

`include "assert_macros.svh"

module vsc_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               src_valid,
    input wire logic               src_stall,
    input wire logic               dst_valid,
    input wire logic               dst_stall,
    input wire vsc_pkg::dst_item_t dst_item
);

    // a stalled result stays put
    `CHK_NEXT(a_dst_hold, clk, rst_n, dst_valid && dst_stall, dst_valid && $stable(dst_item), "dst result changed while stalled")

    // with the output register empty the queue cannot be full
    `CHK_NOW(a_no_stall_when_empty, clk, rst_n, !dst_valid, !src_stall, "src stalled with empty output")

    // input stall only follows a stalled output
    `CHK_NOW(a_stall_cause, clk, rst_n, $rose(src_stall), $past(dst_valid && dst_stall), "src stall without output backpressure")

    // a stall on src never starts without a transfer on src
    `CHK_NEXT(a_stall_needs_traffic, clk, rst_n, !src_valid && !src_stall, !src_stall, "src stall rose without a transfer")

endmodule

bind vigenere_stream_cipher_unit vsc_checker u_vsc_checker (.*);

`default_nettype wire
